@@ rtl/chained_hash_dictionary_macros.svh @@
// ----------------------------------------------------------------------------
// Chained hash dictionary assertion macros
// Shared assertion forms for the dictionary checker.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_DICTIONARY_MACROS_SVH
`define CHAINED_HASH_DICTIONARY_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHD_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

@@ rtl/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained hash dictionary package
// Sizes, action codes and sequencer states shared by the dictionary files.
// ----------------------------------------------------------------------------
package chd_pkg;
   localparam int BUCKETS    = 16;
   localparam int NODES      = 64;
   localparam int VALUE_BITS = 64;
   localparam int BIDX_BITS  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LINK_BITS  = $clog2(NODES + 1);
   localparam int NIDX_BITS  = $clog2(NODES);
   localparam int STEP_BITS  = $clog2(NODES + 1);
   localparam int CFG_BITS   = 5;
   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd5;
   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(NODES);

   typedef logic [1:0] action_type;
   localparam action_type ACT_LOOKUP = 2'd0;
   localparam action_type ACT_INSERT = 2'd1;
   localparam action_type ACT_ADD    = 2'd2;
   localparam action_type ACT_REMOVE = 2'd3;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_MOD, ST_HEAD, ST_READ, ST_CMP, ST_ACT, ST_FREE, ST_RESP
   } state_type;
endpackage

@@ rtl/chd_if.sv @@
// ----------------------------------------------------------------------------
// Chained hash dictionary channels
// Request and response channel interfaces with valid and ready.
// ----------------------------------------------------------------------------
interface chd_req_if;
   import chd_pkg::*;
   logic        valid;
   logic        ready;
   action_type  action;
   logic signed [31:0] key;
   logic [63:0] value_in;
   modport source (output valid, action, key, value_in, input ready);
   modport sink (input valid, action, key, value_in, output ready);
endinterface

interface chd_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] value_out;
   logic        status;
   modport source (output valid, found, value_out, status, input ready);
   modport sink (input valid, found, value_out, status, output ready);
endinterface

@@ rtl/chd_mod.sv @@
// ----------------------------------------------------------------------------
// Chained hash dictionary bucket divider
// Restoring remainder of the key magnitude by the CSR divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module chd_mod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] key,
   input  logic [chd_pkg::CFG_BITS-1:0] divisor,
   output logic        done,
   output logic [chd_pkg::BIDX_BITS-1:0] bucket
);
   import chd_pkg::*;
   logic [31:0] mag_ff, mag_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [5:0]  rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [4:0]  dv;
   logic [5:0]  sh;
   logic [5:0]  fix;

   always_comb begin
      dv = divisor;
      if (dv == 5'd0) dv = 5'd1;
      if (32'(dv) > 32'(BUCKETS)) dv = 5'(BUCKETS);
      sh = {rem_ff[4:0], mag_ff[31]};
      mag_in = mag_ff; rem_in = rem_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      busy_in = busy_ff;
      if (start) begin
         mag_in = key[31] ? (~key + 32'd1) : key;
         neg_in = key[31];
         rem_in = 6'd0; cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (sh >= {1'b0, dv}) ? sh - {1'b0, dv} : sh;
         mag_in = {mag_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mag_ff <= mag_in; rem_ff <= rem_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
   end

   assign fix = (neg_ff && rem_ff != 6'd0) ? ({1'b0, dv} - rem_ff) : rem_ff;
   assign done = !busy_ff && cnt_ff == 6'd0;
   assign bucket = BIDX_BITS'(fix);
endmodule

@@ rtl/chained_hash_dictionary.sv @@
// Sequence: an accepted request runs the bucket divider, then the chain head is loaded
// and each node is read and its key compared until a match or the end of the chain.
// Concurrency: one transaction at a time; a new request is accepted only once the
// previous response has been taken by the receiver.
// Reset: synchronous; an init pass links the pool into a free list,
// during which no request is accepted.
// ----------------------------------------------------------------------------
// Chained hash dictionary
// Separate-chaining dictionary over a fixed node pool with a free list.
// ----------------------------------------------------------------------------
module chained_hash_dictionary (
   input logic clock,
   input logic reset,
   chd_req_if.sink   req,
   chd_rsp_if.source rsp,
   input logic csr_we,
   input logic [chd_pkg::CFG_BITS-1:0] csr_wdata
);
   import chd_pkg::*;
   logic [31:0]            keys_mem [NODES];
   logic [VALUE_BITS-1:0]  vals_mem [NODES];
   logic [LINK_BITS-1:0]   links_mem [NODES];
   logic [LINK_BITS-1:0]   heads_ff [BUCKETS];
   logic [BUCKETS-1:0]     hvalid_ff;

   state_type state_ff, state_in;
   logic [CFG_BITS-1:0]   cfg_ff;
   logic [LINK_BITS-1:0]  free_ff, free_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   action_type            act_ff;
   logic [31:0]           key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [BIDX_BITS-1:0]  bkt_ff, bkt_in;
   logic                  found_ff, found_in, stat_ff, stat_in;
   logic [63:0]           vout_ff, vout_in;
   logic [31:0]           rkey_ff;
   logic [VALUE_BITS-1:0] rval_ff;
   logic [LINK_BITS-1:0]  rlink_ff, fl_ff;
   logic                  mod_start, mod_done;
   logic [BIDX_BITS-1:0]  mod_bucket;
   logic [LINK_BITS-1:0]  head;
   logic                  we_node, we_link, we_head;
   logic [NIDX_BITS-1:0]  wl_addr;
   logic [LINK_BITS-1:0]  wl_data, wh_data;

   chd_mod u_mod (.clock, .reset, .start(mod_start), .key(req.key), .divisor(cfg_ff),
                  .done(mod_done), .bucket(mod_bucket));

   assign head = hvalid_ff[bkt_ff] ? heads_ff[bkt_ff] : NIL;
   assign mod_start = req.valid && req.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: if (step_ff == STEP_BITS'(NODES - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req.valid) state_in = ST_MOD;
         ST_MOD:  if (mod_done) state_in = ST_HEAD;
         ST_HEAD: state_in = ST_READ;
         ST_READ: state_in = (cur_ff == NIL || step_ff == STEP_BITS'(NODES)) ?
                             ST_ACT : ST_CMP;
         ST_CMP:  state_in = (rkey_ff == key_ff) ? ST_ACT : ST_READ;
         ST_ACT:  state_in = ST_FREE;
         ST_FREE: state_in = ST_RESP;
         ST_RESP: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      free_in = free_ff; cur_in = cur_ff; prev_in = prev_ff; step_in = step_ff;
      bkt_in = bkt_ff; found_in = found_ff; stat_in = stat_ff; vout_in = vout_ff;
      we_node = 1'b0; we_link = 1'b0; we_head = 1'b0;
      wl_addr = NIDX_BITS'(step_ff); wl_data = LINK_BITS'(step_ff) + LINK_BITS'(1);
      wh_data = NIL;
      unique case (state_ff)
         ST_INIT: begin
            we_link = 1'b1;
            step_in = step_ff + STEP_BITS'(1);
         end
         ST_IDLE: begin
            found_in = 1'b0; stat_in = 1'b0; vout_in = 64'd0;
         end
         ST_MOD: bkt_in = mod_bucket;
         ST_HEAD: begin
            cur_in = head; prev_in = NIL; step_in = '0;
         end
         ST_READ: ;
         ST_CMP: begin
            if (rkey_ff == key_ff) begin
               found_in = 1'b1;
            end else begin
               prev_in = cur_ff; cur_in = rlink_ff; step_in = step_ff + STEP_BITS'(1);
            end
         end
         ST_ACT: begin
            if (act_ff == ACT_LOOKUP) begin
               if (found_ff) vout_in = 64'(rval_ff);
            end else if (act_ff == ACT_INSERT || (act_ff == ACT_ADD && !found_ff)) begin
               if (free_ff == NIL) begin
                  stat_in = 1'b1;
               end else begin
                  we_node = 1'b1; we_link = 1'b1; we_head = 1'b1;
                  wl_addr = NIDX_BITS'(free_ff); wl_data = head; wh_data = free_ff;
                  free_in = fl_ff;
               end
            end else if (act_ff == ACT_REMOVE && found_ff) begin
               if (prev_ff == NIL) begin
                  we_head = 1'b1; wh_data = rlink_ff;
               end else begin
                  we_link = 1'b1; wl_addr = NIDX_BITS'(prev_ff); wl_data = rlink_ff;
               end
            end
         end
         ST_FREE: begin
            if (act_ff == ACT_REMOVE && found_ff) begin
               we_link = 1'b1; wl_addr = NIDX_BITS'(cur_ff); wl_data = free_ff;
               free_in = cur_ff;
            end
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; cfg_ff <= CFG_RESET; hvalid_ff <= '0;
         step_ff <= '0; free_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; free_ff <= free_in;
         if (csr_we) cfg_ff <= csr_wdata;
         if (we_head) begin
            hvalid_ff[bkt_ff] <= 1'b1;
         end
      end
      if (we_head) heads_ff[bkt_ff] <= wh_data;
      cur_ff <= cur_in; prev_ff <= prev_in; bkt_ff <= bkt_in;
      found_ff <= found_in; stat_ff <= stat_in; vout_ff <= vout_in;
      if (mod_start) begin
         act_ff <= req.action; key_ff <= req.key;
         val_ff <= req.value_in[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we_node) begin
         keys_mem[NIDX_BITS'(free_ff)] <= key_ff;
         vals_mem[NIDX_BITS'(free_ff)] <= val_ff;
      end
      if (we_link) links_mem[wl_addr] <= wl_data;
      rkey_ff  <= keys_mem[NIDX_BITS'(cur_ff)];
      rval_ff  <= vals_mem[NIDX_BITS'(cur_ff)];
      rlink_ff <= links_mem[NIDX_BITS'(cur_ff)];
      fl_ff    <= links_mem[NIDX_BITS'(free_ff)];
   end

   assign req.ready = state_ff == ST_IDLE;
   assign rsp.valid = state_ff == ST_RESP;
   assign rsp.found = found_ff;
   assign rsp.value_out = vout_ff;
   assign rsp.status = stat_ff;
endmodule

@@ rtl/chd_checker.sv @@
// ----------------------------------------------------------------------------
// Chained hash dictionary checker
// Port-level properties of the dictionary, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_dictionary_macros.svh"
module chd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic rsp_status,
   input logic [63:0] rsp_value_out
);
   `CHD_ASSERT_IMP(a_excl, clock, reset, rsp_valid, !req_ready)
   `CHD_ASSERT_IMP(a_stat, clock, reset, rsp_valid && rsp_status, rsp_value_out == 64'd0)
   `CHD_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   `CHD_ASSERT_IMP(a_zero, clock, reset, rsp_valid && !rsp_found, rsp_value_out == 64'd0)
endmodule

bind chained_hash_dictionary chd_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.found),
   .rsp_status(rsp.status), .rsp_value_out(rsp.value_out));
